FILE: hw/rtl/blw_pkg.sv
`timescale 1ns / 1ps

package blw_pkg;

  localparam int COORD_MAX   = 4095;
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 13;
  localparam int DELTA_W     = 13;
  localparam int ERR_W       = 16;
  localparam int COLOR_W     = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR      = 3'd6;

  typedef struct packed {
    logic [COORD_W-1:0] viewport_x;
    logic [COORD_W-1:0] viewport_y;
    logic [SIZE_W-1:0]  viewport_width;
    logic [SIZE_W-1:0]  viewport_height;
    logic [SIZE_W-1:0]  frame_width;
    logic [SIZE_W-1:0]  frame_height;
    logic [COLOR_W-1:0] draw_color;
  } cfg_t;

  typedef struct packed {
    logic                     is_step;
    logic [COORD_W-1:0]       major_start;
    logic [COORD_W-1:0]       major_end;
    logic [COORD_W-1:0]       minor_start;
    logic                     minor_step_down;
    logic                     steep_line;
    logic [DELTA_W-1:0]       twice_major_delta;
    logic [DELTA_W-1:0]       twice_minor_delta;
    logic signed [ERR_W-1:0]  error_init;
  } cmd_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    r = v;
    if (32'(v) > COORD_MAX) begin
      r = COORD_W'(COORD_MAX);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/blw_if.sv
`timescale 1ns / 1ps

interface blw_line_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [blw_pkg::COORD_W-1:0]  start_x;
  logic [blw_pkg::COORD_W-1:0]  start_y;
  logic [blw_pkg::COORD_W-1:0]  end_x;
  logic [blw_pkg::COORD_W-1:0]  end_y;

  modport source (output valid, action, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blw_pixel_if;
  logic                         valid;
  logic                         ready;
  logic                         pixel_valid;
  logic [blw_pkg::COORD_W-1:0]  pixel_x;
  logic [blw_pkg::COORD_W-1:0]  pixel_y;
  logic [blw_pkg::COLOR_W-1:0]  pixel_color;
  logic                         pixel_inside;
  logic                         last_pixel;

  modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, pixel_inside,
                  last_pixel, input ready);
  modport sink (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, pixel_inside,
                last_pixel, output ready);
endinterface

FILE: hw/rtl/blw_front.sv
`timescale 1ns / 1ps

module blw_front (
  blw_line_if.sink        line_req,
  input  logic            queue_full,
  output logic            push,
  output blw_pkg::cmd_t   cmd
);

  logic [blw_pkg::COORD_W-1:0] ax, ay, bx, by;
  logic [blw_pkg::COORD_W-1:0] dx, dy;
  logic                        steep;
  logic [blw_pkg::COORD_W-1:0] sa_major, sa_minor, sb_major, sb_minor;
  logic [blw_pkg::COORD_W-1:0] lo_major, lo_minor, hi_major, hi_minor;
  logic [blw_pkg::COORD_W-1:0] d_major, d_minor;

  assign line_req.ready = !queue_full;
  assign push = line_req.valid && !queue_full;

  always_comb begin
    ax = blw_pkg::sat_coord(line_req.start_x);
    ay = blw_pkg::sat_coord(line_req.start_y);
    bx = blw_pkg::sat_coord(line_req.end_x);
    by = blw_pkg::sat_coord(line_req.end_y);
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    steep = dy > dx;
    sa_major = steep ? ay : ax;
    sa_minor = steep ? ax : ay;
    sb_major = steep ? by : bx;
    sb_minor = steep ? bx : by;
    if (sa_major > sb_major) begin
      lo_major = sb_major;
      lo_minor = sb_minor;
      hi_major = sa_major;
      hi_minor = sa_minor;
    end else begin
      lo_major = sa_major;
      lo_minor = sa_minor;
      hi_major = sb_major;
      hi_minor = sb_minor;
    end
    d_major = hi_major - lo_major;
    d_minor = (lo_minor > hi_minor) ? lo_minor - hi_minor : hi_minor - lo_minor;

    cmd.is_step           = (line_req.action == blw_pkg::ACT_STEP);
    cmd.major_start       = lo_major;
    cmd.major_end         = hi_major;
    cmd.minor_start       = lo_minor;
    cmd.minor_step_down   = lo_minor > hi_minor;
    cmd.steep_line        = steep;
    cmd.twice_major_delta = {d_major, 1'b0};
    cmd.twice_minor_delta = {d_minor, 1'b0};
    cmd.error_init        = $signed(blw_pkg::ERR_W'({d_minor, 1'b0}))
                            - $signed(blw_pkg::ERR_W'(d_major));
  end

endmodule

FILE: hw/rtl/blw_queue.sv
`timescale 1ns / 1ps

module blw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  blw_pkg::cmd_t   push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output blw_pkg::cmd_t   head_cmd
);

  localparam int PTR_W = (blw_pkg::QUEUE_DEPTH > 1) ? $clog2(blw_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(blw_pkg::QUEUE_DEPTH + 1);

  blw_pkg::cmd_t    slots [blw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = p + 1'b1;
    if (32'(p) == blw_pkg::QUEUE_DEPTH - 1) begin
      r = '0;
    end
    return r;
  endfunction

  assign full       = (32'(count) == blw_pkg::QUEUE_DEPTH);
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && head_valid)) begin
      count_next = count + 1'b1;
    end else if (!push && pop && head_valid) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop && head_valid) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/blw_back.sv
`timescale 1ns / 1ps

module blw_back (
  input  logic            clk,
  input  logic            rst,
  input  blw_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  blw_pkg::cmd_t   head_cmd,
  output logic            pop,
  blw_pixel_if.source     pixel_rsp
);

  logic [blw_pkg::COORD_W-1:0]      major_pos;
  logic [blw_pkg::COORD_W-1:0]      minor_pos;
  logic [blw_pkg::COORD_W-1:0]      major_end;
  logic signed [blw_pkg::ERR_W-1:0] error_term;
  logic [blw_pkg::DELTA_W-1:0]      twice_major_delta;
  logic [blw_pkg::DELTA_W-1:0]      twice_minor_delta;
  logic                             minor_step_down;
  logic                             steep_line;
  logic                             line_active;

  logic                             out_valid;
  logic                             out_pixel_valid;
  logic [blw_pkg::COORD_W-1:0]      out_x;
  logic [blw_pkg::COORD_W-1:0]      out_y;
  logic [blw_pkg::COLOR_W-1:0]      out_color;
  logic                             out_inside;
  logic                             out_last;

  logic                             out_free;
  logic                             do_load;
  logic                             do_step;
  logic [blw_pkg::COORD_W-1:0]      px;
  logic [blw_pkg::COORD_W-1:0]      py;
  logic [blw_pkg::COORD_W+1:0]      bound_x;
  logic [blw_pkg::COORD_W+1:0]      bound_y;
  logic                             in_clip;
  logic                             last;
  logic [blw_pkg::COORD_W-1:0]      minor_pos_next;
  logic signed [blw_pkg::ERR_W-1:0] error_term_next;

  assign out_free = !out_valid || pixel_rsp.ready;
  assign do_load  = head_valid && !head_cmd.is_step;
  assign do_step  = head_valid && head_cmd.is_step && out_free;
  assign pop      = do_load || do_step;

  always_comb begin
    px = steep_line ? minor_pos : major_pos;
    py = steep_line ? major_pos : minor_pos;
    bound_x = (blw_pkg::COORD_W+2)'(cfg.viewport_x) + (blw_pkg::COORD_W+2)'(cfg.viewport_width);
    bound_y = (blw_pkg::COORD_W+2)'(cfg.viewport_y)
              + (blw_pkg::COORD_W+2)'(cfg.viewport_height);
    in_clip = ((blw_pkg::COORD_W+2)'(px) < bound_x) && ((blw_pkg::COORD_W+2)'(py) < bound_y)
              && (blw_pkg::SIZE_W'(px) < cfg.frame_width)
              && (blw_pkg::SIZE_W'(py) < cfg.frame_height);
    last = (blw_pkg::COORD_W+1)'(major_pos) + 1'b1 >= (blw_pkg::COORD_W+1)'(major_end);
    minor_pos_next  = minor_pos;
    error_term_next = error_term + $signed(blw_pkg::ERR_W'(twice_minor_delta));
    if (error_term > 0) begin
      minor_pos_next  = minor_step_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
      error_term_next = error_term_next - $signed(blw_pkg::ERR_W'(twice_major_delta));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (do_load) begin
      line_active <= head_cmd.major_start < head_cmd.major_end;
    end else if (do_step && line_active && last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      major_pos         <= head_cmd.major_start;
      major_end         <= head_cmd.major_end;
      minor_pos         <= head_cmd.minor_start;
      error_term        <= head_cmd.error_init;
      twice_major_delta <= head_cmd.twice_major_delta;
      twice_minor_delta <= head_cmd.twice_minor_delta;
      minor_step_down   <= head_cmd.minor_step_down;
      steep_line        <= head_cmd.steep_line;
    end else if (do_step && line_active) begin
      major_pos  <= major_pos + 1'b1;
      minor_pos  <= minor_pos_next;
      error_term <= error_term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= do_step;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      out_pixel_valid <= line_active;
      out_x           <= line_active ? px : '0;
      out_y           <= line_active ? py : '0;
      out_color       <= line_active ? cfg.draw_color : '0;
      out_inside      <= line_active && in_clip;
      out_last        <= line_active && last;
    end
  end

  assign pixel_rsp.valid        = out_valid;
  assign pixel_rsp.pixel_valid  = out_pixel_valid;
  assign pixel_rsp.pixel_x      = out_x;
  assign pixel_rsp.pixel_y      = out_y;
  assign pixel_rsp.pixel_color  = out_color;
  assign pixel_rsp.pixel_inside = out_inside;
  assign pixel_rsp.last_pixel   = out_last;

  a_active_in_range: assert property (@(posedge clk) disable iff (rst)
    line_active |-> major_pos < major_end)
    else $error("active line past its end");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    do_step && line_active && last |=> !line_active)
    else $error("line still active after last pixel");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pixel_valid |-> !out_inside && !out_last && out_x == '0 && out_y == '0)
    else $error("result without a line is not cleared");

  a_step_needs_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_rsp.ready |-> !do_step)
    else $error("step taken while output stalled");

endmodule

FILE: hw/rtl/bresenham_line_walker.sv
`timescale 1ns / 1ps
// output: an accepted step request's pixel is held in the registered output stage
// throughput: one request per cycle; loads always, steps while the output is free
// the step unit updates error term and position together, which sets the rate
// reset: synchronous, clears the queue, the output register, the pending line and
// all configuration registers

module bresenham_line_walker (
  input  logic                             clk,
  input  logic                             rst,
  blw_line_if.sink                         line_req,
  blw_pixel_if.source                      pixel_rsp,
  input  logic                             cfg_we,
  input  logic [blw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  blw_pkg::cfg_t cfg;
  blw_pkg::cmd_t push_cmd;
  blw_pkg::cmd_t head_cmd;
  logic          push;
  logic          queue_full;
  logic          pop;
  logic          head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        blw_pkg::REG_VIEWPORT_X:      cfg.viewport_x      <= cfg_data[blw_pkg::COORD_W-1:0];
        blw_pkg::REG_VIEWPORT_Y:      cfg.viewport_y      <= cfg_data[blw_pkg::COORD_W-1:0];
        blw_pkg::REG_VIEWPORT_WIDTH:  cfg.viewport_width  <= cfg_data[blw_pkg::SIZE_W-1:0];
        blw_pkg::REG_VIEWPORT_HEIGHT: cfg.viewport_height <= cfg_data[blw_pkg::SIZE_W-1:0];
        blw_pkg::REG_FRAME_WIDTH:     cfg.frame_width     <= cfg_data[blw_pkg::SIZE_W-1:0];
        blw_pkg::REG_FRAME_HEIGHT:    cfg.frame_height    <= cfg_data[blw_pkg::SIZE_W-1:0];
        blw_pkg::REG_DRAW_COLOR:      cfg.draw_color      <= cfg_data[blw_pkg::COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  blw_front u_front (
    .line_req   (line_req),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  blw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  blw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .pixel_rsp  (pixel_rsp)
  );

endmodule

FILE: verif/blw_pixel_checker.sv
`timescale 1ns / 1ps

module blw_pixel_checker
  import blw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  blw_line_if                   line_req,
  blw_pixel_if                  pixel_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               pixel_inside;
    logic               last_pixel;
  } pixel_t;

  pixel_t expected_pixels[$];
  cfg_t   regs;

  logic [COORD_W-1:0] walk_major;
  logic [COORD_W-1:0] walk_minor;
  logic [COORD_W-1:0] walk_end;
  int                 walk_err;
  int                 walk_dmaj2;
  int                 walk_dmin2;
  logic               walk_down;
  logic               walk_steep;
  logic               walk_busy;

  int mismatches = 0;
  int outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  function automatic int clamp_coord(input logic [COORD_W-1:0] v);
    return (int'(v) > COORD_MAX) ? COORD_MAX : int'(v);
  endfunction

  function automatic int abs_gap(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic predict_request(input logic act, input logic [COORD_W-1:0] sx,
                                 input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] ex,
                                 input logic [COORD_W-1:0] ey);
    int     ax;
    int     ay;
    int     bx;
    int     by;
    int     t;
    int     px;
    int     py;
    logic   last_one;
    logic   in_clip;
    pixel_t pix;
    pix = '0;
    if (act == ACT_LOAD) begin
      ax = clamp_coord(sx);
      ay = clamp_coord(sy);
      bx = clamp_coord(ex);
      by = clamp_coord(ey);
      walk_steep = abs_gap(by, ay) > abs_gap(bx, ax);
      if (walk_steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      walk_dmaj2 = 2 * (bx - ax);
      walk_dmin2 = 2 * abs_gap(by, ay);
      walk_err   = walk_dmin2 - (bx - ax);
      walk_major = COORD_W'(ax);
      walk_end   = COORD_W'(bx);
      walk_minor = COORD_W'(ay);
      walk_down  = ay > by;
      walk_busy  = ax < bx;
    end else if (!walk_busy) begin
      expected_pixels.push_back(pix);
    end else begin
      px = walk_steep ? int'(walk_minor) : int'(walk_major);
      py = walk_steep ? int'(walk_major) : int'(walk_minor);
      in_clip = (px < int'(regs.viewport_x) + int'(regs.viewport_width)) &&
                (py < int'(regs.viewport_y) + int'(regs.viewport_height)) &&
                (px < int'(regs.frame_width)) && (py < int'(regs.frame_height));
      last_one = int'(walk_major) + 1 >= int'(walk_end);
      pix.pixel_valid  = 1'b1;
      pix.pixel_x      = COORD_W'(px);
      pix.pixel_y      = COORD_W'(py);
      pix.pixel_color  = regs.draw_color;
      pix.pixel_inside = in_clip;
      pix.last_pixel   = last_one;
      expected_pixels.push_back(pix);
      if (walk_err > 0) begin
        walk_minor = walk_down ? walk_minor - 1'b1 : walk_minor + 1'b1;
        walk_err   = walk_err - walk_dmaj2;
      end
      walk_err   = walk_err + walk_dmin2;
      walk_major = walk_major + 1'b1;
      if (last_one) begin
        walk_busy = 1'b0;
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t got;
    pixel_t want;
    got.pixel_valid  = pixel_rsp.pixel_valid;
    got.pixel_x      = pixel_rsp.pixel_x;
    got.pixel_y      = pixel_rsp.pixel_y;
    got.pixel_color  = pixel_rsp.pixel_color;
    got.pixel_inside = pixel_rsp.pixel_inside;
    got.last_pixel   = pixel_rsp.last_pixel;
    if (expected_pixels.size() == 0) begin
      if (mismatches < REPORT_MAX) begin
        $display("unexpected pixel: valid=%0d x=%0d y=%0d color=%06h inside=%0d last=%0d",
                 got.pixel_valid, got.pixel_x, got.pixel_y, got.pixel_color,
                 got.pixel_inside, got.last_pixel);
      end
      mismatches++;
    end else begin
      want = expected_pixels.pop_front();
      if (got !== want) begin
        if (mismatches < REPORT_MAX) begin
          $display("pixel mismatch: expected valid=%0d x=%0d y=%0d color=%06h inside=%0d last=%0d",
                   want.pixel_valid, want.pixel_x, want.pixel_y, want.pixel_color,
                   want.pixel_inside, want.last_pixel);
          $display("                got      valid=%0d x=%0d y=%0d color=%06h inside=%0d last=%0d",
                   got.pixel_valid, got.pixel_x, got.pixel_y, got.pixel_color,
                   got.pixel_inside, got.last_pixel);
        end
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs       = '0;
      walk_major = '0;
      walk_minor = '0;
      walk_end   = '0;
      walk_err   = 0;
      walk_dmaj2 = 0;
      walk_dmin2 = 0;
      walk_down  = 1'b0;
      walk_steep = 1'b0;
      walk_busy  = 1'b0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VIEWPORT_X:      regs.viewport_x      = cfg_data[COORD_W-1:0];
          REG_VIEWPORT_Y:      regs.viewport_y      = cfg_data[COORD_W-1:0];
          REG_VIEWPORT_WIDTH:  regs.viewport_width  = cfg_data[SIZE_W-1:0];
          REG_VIEWPORT_HEIGHT: regs.viewport_height = cfg_data[SIZE_W-1:0];
          REG_FRAME_WIDTH:     regs.frame_width     = cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT:    regs.frame_height    = cfg_data[SIZE_W-1:0];
          REG_DRAW_COLOR:      regs.draw_color      = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (line_req.valid && line_req.ready) begin
        predict_request(line_req.action, line_req.start_x, line_req.start_y,
                        line_req.end_x, line_req.end_y);
      end
      if (pixel_rsp.valid && pixel_rsp.ready) begin
        check_pixel();
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import blw_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 175;
  localparam int PHASE_COUNT  = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {CFG_ZERO, CFG_MAX, CFG_RANDOM, CFG_JUNK} cfg_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;
  int cycle_count = 0;

  blw_line_if  line_req();
  blw_pixel_if pixel_rsp();

  bresenham_line_walker dut (
    .clk       (clk),
    .rst       (rst),
    .line_req  (line_req),
    .pixel_rsp (pixel_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  blw_pixel_checker pixel_check (
    .clk        (clk),
    .rst        (rst),
    .line_req   (line_req),
    .pixel_rsp  (pixel_rsp),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    pixel_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      pixel_rsp.ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
    end
  end

  function automatic logic [COORD_W-1:0] pick_coord();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return COORD_W'(COORD_MAX);
    end
    return COORD_W'($urandom);
  endfunction

  function automatic logic [COORD_W-1:0] fit_coord(input int v);
    if (v < 0) begin
      return '0;
    end else if (v > COORD_MAX) begin
      return COORD_W'(COORD_MAX);
    end
    return COORD_W'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(input cfg_kind_t kind, input int max,
                                                      input int width);
    logic [CFG_DATA_W-1:0] v;
    case (kind)
      CFG_ZERO:   v = '0;
      CFG_MAX:    v = CFG_DATA_W'(max);
      CFG_RANDOM: v = CFG_DATA_W'($urandom_range(max));
      default: begin
        v = CFG_DATA_W'($urandom_range(max));
        if (width < CFG_DATA_W) begin
          v = v | (CFG_DATA_W'($urandom) << width);
        end
      end
    endcase
    return v;
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 46; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 46; end
      default:       begin send_idle_pct = 15; stall_pct = 15; end
    endcase
  endtask

  task automatic send_req(input logic act, input logic [COORD_W-1:0] sx,
                          input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] ex,
                          input logic [COORD_W-1:0] ey);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      line_req.valid   <= 1'b0;
      line_req.action  <= 1'($urandom);
      line_req.start_x <= COORD_W'($urandom);
      line_req.start_y <= COORD_W'($urandom);
      line_req.end_x   <= COORD_W'($urandom);
      line_req.end_y   <= COORD_W'($urandom);
      @(negedge clk);
    end
    line_req.valid   <= 1'b1;
    line_req.action  <= act;
    line_req.start_x <= sx;
    line_req.start_y <= sy;
    line_req.end_x   <= ex;
    line_req.end_y   <= ey;
    @(posedge clk);
    while (!line_req.ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic step_line(input int n);
    repeat (n) begin
      send_req(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    line_req.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic write_regs(input cfg_kind_t kind);
    write_reg(REG_VIEWPORT_X,      reg_value(kind, COORD_MAX, COORD_W));
    write_reg(REG_VIEWPORT_Y,      reg_value(kind, COORD_MAX, COORD_W));
    write_reg(REG_VIEWPORT_WIDTH,  reg_value(kind, COORD_MAX + 1, SIZE_W));
    write_reg(REG_VIEWPORT_HEIGHT, reg_value(kind, COORD_MAX + 1, SIZE_W));
    write_reg(REG_FRAME_WIDTH,     reg_value(kind, COORD_MAX + 1, SIZE_W));
    write_reg(REG_FRAME_HEIGHT,    reg_value(kind, COORD_MAX + 1, SIZE_W));
    write_reg(REG_DRAW_COLOR,      reg_value(kind, 24'hFFFFFF, COLOR_W));
    write_reg(REG_UNUSED,          CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_sequence();
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    int roll;
    int span;
    int dx;
    int dy;
    int t;
    int steps;
    roll = $urandom_range(99);
    sx = pick_coord();
    sy = pick_coord();
    if (roll < 4) begin
      step_line(1);
    end else if (roll < 8) begin
      send_req(ACT_LOAD, sx, sy, sx, sy);
      step_line(1);
    end else if (roll < 14) begin
      ex = pick_coord();
      ey = pick_coord();
      send_req(ACT_LOAD, sx, sy, ex, ey);
      step_line($urandom_range(0, 6));
    end else begin
      // pending line replaced before any step
      if (roll < 20) begin
        send_req(ACT_LOAD, pick_coord(), pick_coord(), pick_coord(), pick_coord());
      end
      span = ($urandom_range(19) == 0) ? $urandom_range(13, 100) : $urandom_range(1, 12);
      dx = span;
      dy = $urandom_range(0, span);
      if ($urandom_range(1) == 1) begin
        t = dx; dx = dy; dy = t;
      end
      if ($urandom_range(1) == 1) dx = -dx;
      if ($urandom_range(1) == 1) dy = -dy;
      ex = fit_coord(int'(sx) + dx);
      ey = fit_coord(int'(sy) + dy);
      dx = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
      dy = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
      steps = (dx > dy) ? dx : dy;
      if ($urandom_range(4) == 0) begin
        steps = $urandom_range(0, steps);
      end else begin
        steps = steps + $urandom_range(0, 2);
      end
      send_req(ACT_LOAD, sx, sy, ex, ey);
      step_line(steps);
    end
  endtask

  initial begin
    int start_count;
    rst              = 1'b1;
    line_req.valid   = 1'b0;
    line_req.action  = ACT_LOAD;
    line_req.start_x = '0;
    line_req.start_y = '0;
    line_req.end_x   = '0;
    line_req.end_y   = '0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_regs(CFG_MAX);
    step_line(1);
    send_req(ACT_LOAD, 12'd7, 12'd7, 12'd7, 12'd7);
    step_line(1);
    send_req(ACT_LOAD, 12'd0, 12'd0, 12'd3, 12'd3);
    step_line(4);
    send_req(ACT_LOAD, 12'd10, 12'd2, 12'd4, 12'd5);
    step_line(6);
    send_req(ACT_LOAD, 12'd5, 12'd0, 12'd3, 12'd4);
    step_line(2);
    send_req(ACT_LOAD, 12'd4095, 12'd4095, 12'd0, 12'd0);
    step_line(2);
    send_req(ACT_LOAD, 12'd0, 12'd4095, 12'd4095, 12'd0);
    step_line(2);
    send_req(ACT_LOAD, 12'd4095, 12'd0, 12'd4095, 12'd2);
    step_line(2);
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_idle(idle_mode_t'(p / 2));
      write_regs(cfg_kind_t'(p % 4));
      start_count = sent_items;
      while (sent_items - start_count < PHASE_ITEMS) random_sequence();
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
